/* rtl/spso_pkg.sv */
`default_nettype none

package spso_pkg;

  // Clamp limit of the pitch offset, in semitones
  localparam int PitchLimit = 48;

  // Reset value of the base phase step: 440 Hz at 44.1 kHz, 2^32 per cycle
  localparam logic [31:0] BASE_INC_RESET = 32'd42852281;

  // Width of the semitone ratio (unsigned Q1.16) and of base step times ratio
  localparam int RATIO_W = 17;
  localparam int PROD_W  = 32 + RATIO_W;

  // pi/2 in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic [3:0] semi;   // ratio table index, 0..11
    logic [4:0] shift;  // right shift of the product, 12..20
  } pitch_dec_t;

  // round(2^(k/12) * 2^16)
  function automatic logic [RATIO_W-1:0] semi_ratio(input logic [3:0] idx);
    logic [RATIO_W-1:0] r;
    unique case (idx)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd69433;
      4'd2:    r = 17'd73562;
      4'd3:    r = 17'd77936;
      4'd4:    r = 17'd82570;
      4'd5:    r = 17'd87480;
      4'd6:    r = 17'd92682;
      4'd7:    r = 17'd98193;
      4'd8:    r = 17'd104032;
      4'd9:    r = 17'd110218;
      4'd10:   r = 17'd116772;
      4'd11:   r = 17'd123715;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Clamp to +/-48, then split offset+48 into octave and semitone.
  // offset+48 stays below 97, so *171 >> 11 gives the exact quotient by 12.
  function automatic pitch_dec_t pitch_decode(input logic [6:0] raw);
    logic signed [6:0] off;
    logic [6:0]        v;
    logic [14:0]       prod;
    logic [3:0]        q;
    logic [6:0]        r;
    pitch_dec_t        d;
    off = signed'(raw);
    if (off > 7'sd48) begin
      off = 7'sd48;
    end else if (off < -7'sd48) begin
      off = -7'sd48;
    end
    v       = 7'(unsigned'(off) + 7'd48);
    prod    = 15'(v) * 15'd171;
    q       = prod[14:11];
    r       = v - (7'(q) * 7'd12);
    d.semi  = r[3:0];
    d.shift = 5'd20 - 5'(q);
    return d;
  endfunction

  // sin(x) in Q30 by Taylor series to x^11; used only at elaboration
  function automatic logic signed [63:0] sine_q30(input logic [63:0] x);
    logic [63:0]        xx;
    logic [63:0]        mag;
    logic signed [63:0] sum;
    int                 n;
    xx  = (x * x) >> 30;
    mag = x;
    sum = signed'(x);
    for (n = 1; n <= 5; n++) begin
      mag = (mag * xx) >> 30;
      unique case (n)
        1:       mag = mag / 64'd6;
        2:       mag = mag / 64'd20;
        3:       mag = mag / 64'd42;
        4:       mag = mag / 64'd72;
        default: mag = mag / 64'd110;
      endcase
      if ((n % 2) == 1) begin
        sum = sum - signed'(mag);
      end else begin
        sum = sum + signed'(mag);
      end
    end
    return sum;
  endfunction

endpackage

`default_nettype wire

/* rtl/semitone_pitched_sine_oscillator_core.sv */
`default_nettype none

// Semitone-pitched DDS sine oscillator.
// Slave stream: one transaction asks for one stereo frame. tdata[6:0] is the
//   signed pitch offset in semitones (clamped to +/-48), tlast marks the last
//   frame of a buffer. Master stream: tdata carries the signed sine sample
//   (same for left and right), tlast is the copied buffer marker.
// Configuration: cfg_wr_en_i writes cfg_wr_data_i into the base phase step
//   (phase LSBs per sample at zero offset); write it only while idle.
// Pipeline: an input transaction reaches output valid through an
//   input register (pitch decode), a product register (base step times the
//   semitone ratio, one 32x17 multiply) and the output register (phase add
//   and quarter-wave table lookup). Throughput: one frame every cycle when
//   the output is not stalled; the phase accumulator add is the only feedback path.
// Reset: phase returns to zero, the base step to 440 Hz at 44.1 kHz, and
//   the pipeline empties.
// Stall: each stage holds while the stage after it is full and blocked, so
//   while the receiver holds tready low up to three frames sit in the block
//   before s_axis_tready drops. Nothing is dropped or repeated.
module semitone_pitched_sine_oscillator_core
  import spso_pkg::*;
#(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // slave stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [7:0]             s_axis_tdata,   // [6:0] pitch_semitones
  input  wire logic                   s_axis_tlast,   // last_of_block
  // master stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata, // [SAMPLE_BITS-1:0] sample
  output logic                        m_axis_tlast,   // last
  // base phase step register
  input  wire logic                   cfg_wr_en_i,
  input  wire logic [31:0]            cfg_wr_data_i
);

  logic [31:0]            base_inc_q;

  // input stage
  logic                   in_vld_q;
  pitch_dec_t             dec_q;
  logic                   in_last_q;
  logic                   in_rdy;

  // product stage
  logic                   p_vld_q;
  logic [PROD_W-1:0]      prod_q;
  logic [4:0]             shift_q;
  logic                   p_last_q;
  logic                   p_rdy;
  logic [PROD_W-1:0]      prod_d;

  // output stage and phase
  logic                   out_vld_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [SAMPLE_BITS-1:0] sample_d;
  logic                   out_last_q;
  logic                   out_rdy;
  logic [PHASE_BITS-1:0]  phase_q;
  logic [PROD_W-1:0]      inc_full;
  logic [PHASE_BITS-1:0]  phase_d;

  // A stage takes a new entry when empty or when its content moves on
  assign out_rdy       = !out_vld_q || m_axis_tready;
  assign p_rdy         = !p_vld_q || out_rdy;
  assign in_rdy        = !in_vld_q || p_rdy;
  assign s_axis_tready = in_rdy;

  assign prod_d   = PROD_W'(base_inc_q) * PROD_W'(semi_ratio(dec_q.semi));
  assign inc_full = prod_q >> shift_q;
  assign phase_d  = phase_q + inc_full[PHASE_BITS-1:0];

  // Sample of the phase before this frame's step
  spso_sine_rom #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_sine_rom (
    .idx_i    (phase_q[PHASE_BITS-1 -: SINE_TABLE_BITS]),
    .sample_o (sample_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_inc_q <= BASE_INC_RESET;
      in_vld_q   <= 1'b0;
      p_vld_q    <= 1'b0;
      out_vld_q  <= 1'b0;
      phase_q    <= '0;
    end else begin
      if (cfg_wr_en_i) begin
        base_inc_q <= cfg_wr_data_i;
      end
      if (in_rdy) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (p_rdy) begin
        p_vld_q <= in_vld_q;
      end
      if (out_rdy) begin
        out_vld_q <= p_vld_q;
      end
      // advance the accumulator as the frame leaves the product stage
      if (p_vld_q && out_rdy) begin
        phase_q <= phase_d;
      end
    end
  end

  // payload: no reset
  always_ff @(posedge clk_i) begin
    if (in_rdy && s_axis_tvalid) begin
      dec_q     <= pitch_decode(s_axis_tdata[6:0]);
      in_last_q <= s_axis_tlast;
    end
    if (p_rdy && in_vld_q) begin
      prod_q   <= prod_d;
      shift_q  <= dec_q.shift;
      p_last_q <= in_last_q;
    end
    if (out_rdy && p_vld_q) begin
      sample_q   <= sample_d;
      out_last_q <= p_last_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tlast  = out_last_q;

  always_comb begin
    m_axis_tdata                  = '0;
    m_axis_tdata[SAMPLE_BITS-1:0] = sample_q;
  end

endmodule

`default_nettype wire

/* rtl/spso_sine_rom.sv */
`default_nettype none

module spso_sine_rom
  import spso_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  wire logic [SINE_TABLE_BITS-1:0]    idx_i,
  output logic signed [SAMPLE_BITS-1:0]      sample_o
);

  localparam int QBITS       = SINE_TABLE_BITS - 2;
  localparam int QUARTER_LEN = 1 << QBITS;
  localparam logic [SAMPLE_BITS-2:0] AMP = {(SAMPLE_BITS-1){1'b1}};

  typedef logic [SAMPLE_BITS-2:0] qsine_t [QUARTER_LEN+1];

  function automatic qsine_t build_qsine();
    qsine_t             t;
    logic [63:0]        x;
    logic signed [63:0] s;
    logic [63:0]        v;
    int                 j;
    for (j = 0; j <= QUARTER_LEN; j++) begin
      x = (HALF_PI_Q30 * 64'(j)) >> QBITS;
      s = sine_q30(x);
      if (s < 0) begin
        s = '0;
      end
      v = ((unsigned'(s) * 64'(AMP)) + (64'd1 << 29)) >> 30;
      if (v > 64'(AMP)) begin
        v = 64'(AMP);
      end
      t[j] = v[SAMPLE_BITS-2:0];
    end
    return t;
  endfunction

  localparam qsine_t QSINE = build_qsine();

  logic [1:0]             quad;
  logic [QBITS-1:0]       j;
  logic [QBITS:0]         addr;
  logic [SAMPLE_BITS-2:0] mag;

  // Mirror the odd quadrants, negate the lower half-cycle
  always_comb begin
    quad = idx_i[SINE_TABLE_BITS-1 -: 2];
    j    = idx_i[QBITS-1:0];
    if (quad[0]) begin
      addr = (QBITS+1)'(QUARTER_LEN) - {1'b0, j};
    end else begin
      addr = {1'b0, j};
    end
    mag = QSINE[addr];
    if (quad[1]) begin
      sample_o = -signed'({1'b0, mag});
    end else begin
      sample_o = signed'({1'b0, mag});
    end
  end

endmodule

`default_nettype wire

/* bench/sine_frame_checker.sv */
`timescale 1ns / 1ps

module sine_frame_checker
  import spso_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [6:0] pitch_semitones
  input  wire logic        s_axis_tlast,   // last_of_block
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [15:0] m_axis_tdata,   // [15:0] sample
  input  wire logic        m_axis_tlast,   // last
  input  wire logic        cfg_wr_en_i,
  input  wire logic [31:0] cfg_wr_data_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               frames_checked_o
);

  localparam int QuarterLen = 256;
  localparam longint unsigned Amp = 64'd32767;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } frame_t;

  // round(2^(k/12) * 2^16)
  localparam logic [16:0] SemiRatio [12] = '{
    17'd65536, 17'd69433, 17'd73562, 17'd77936, 17'd82570, 17'd87480,
    17'd92682, 17'd98193, 17'd104032, 17'd110218, 17'd116772, 17'd123715
  };

  logic signed [15:0] quarter_wave [QuarterLen+1];
  logic [31:0]        track_phase = '0;
  logic [31:0]        step_reg    = BASE_INC_RESET;
  frame_t             due_frames [$];

  function automatic longint taylor_sin_q30(input longint unsigned x);
    longint unsigned sq;
    longint unsigned term;
    longint          acc;
    int              k;
    sq   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (k = 1; k <= 5; k++) begin
      term = (term * sq) >> 30;
      term = term / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc -= longint'(term);
      end else begin
        acc += longint'(term);
      end
    end
    return acc;
  endfunction

  initial begin
    longint unsigned x;
    longint          s;
    longint unsigned v;
    for (int j = 0; j <= QuarterLen; j++) begin
      x = (HALF_PI_Q30 * longint'(j)) / QuarterLen;
      s = taylor_sin_q30(x);
      if (s < 0) begin
        s = 0;
      end
      v = ((longint'(s) * Amp) + (64'd1 << 29)) >> 30;
      if (v > Amp) begin
        v = Amp;
      end
      quarter_wave[j] = 16'(v);
    end
  end

  function automatic logic signed [15:0] phase_to_sample(input logic [31:0] ph);
    logic [9:0]         idx;
    logic signed [15:0] mag;
    idx = ph[31:22];
    mag = idx[8] ? quarter_wave[QuarterLen - int'(idx[7:0])] : quarter_wave[idx[7:0]];
    return idx[9] ? -mag : mag;
  endfunction

  function automatic logic [31:0] step_for_pitch(input logic [6:0] raw);
    int          off;
    int          v;
    int          octave;
    int          semi;
    logic [63:0] prod;
    off = int'($signed(raw));
    if (off > PitchLimit) begin
      off = PitchLimit;
    end else if (off < -PitchLimit) begin
      off = -PitchLimit;
    end
    // floor division: offset + 48 is never negative
    v      = off + PitchLimit;
    octave = v / 12 - PitchLimit / 12;
    semi   = v % 12;
    prod   = 64'(step_reg) * 64'(SemiRatio[semi]);
    return 32'(prod >> (16 - octave));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_t want;
    if (!rst_ni) begin
      track_phase      = '0;
      step_reg         = BASE_INC_RESET;
      due_frames.delete();
      pending_o        = 0;
      fail_count_o     = 0;
      frames_checked_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_frames.size() == 0) begin
          $error("unexpected frame: sample %0d, last %0b",
                 $signed(m_axis_tdata), m_axis_tlast);
          fail_count_o++;
        end else begin
          want = due_frames.pop_front();
          frames_checked_o++;
          if (want.sample !== $signed(m_axis_tdata)) begin
            $error("sample mismatch: expected %0d, got %0d",
                   want.sample, $signed(m_axis_tdata));
            fail_count_o++;
          end
          if (want.last !== m_axis_tlast) begin
            $error("last mismatch: expected %0b, got %0b", want.last, m_axis_tlast);
            fail_count_o++;
          end
        end
      end
      // sample first, then advance the accumulator
      if (s_axis_tvalid && s_axis_tready) begin
        want.sample = phase_to_sample(track_phase);
        want.last   = s_axis_tlast;
        due_frames.push_back(want);
        track_phase = track_phase + step_for_pitch(s_axis_tdata[6:0]);
      end
      if (cfg_wr_en_i) begin
        step_reg = cfg_wr_data_i;
      end
      pending_o = due_frames.size();
    end
  end

endmodule

/* bench/semitone_pitched_sine_oscillator_core_test.sv */
`timescale 1ns / 1ps

module semitone_pitched_sine_oscillator_core_test;
  import spso_pkg::*;

  localparam int PhaseCount    = 8;
  localparam int ItemsPerPhase = 50;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [6:0] pitch_semitones
  logic        s_axis_tlast  = 1'b0; // last_of_block
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [15:0] sample
  logic        m_axis_tlast;         // last
  logic        cfg_wr_en_i   = 1'b0;
  logic [31:0] cfg_wr_data_i = '0;

  int fail_count;
  int pending;
  int frames_checked;

  // Pacing knobs, in percent of cycles
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int settings_used  = 0;

  semitone_pitched_sine_oscillator_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i)
  );

  sine_frame_checker checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tlast     (s_axis_tlast),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tlast     (m_axis_tlast),
    .cfg_wr_en_i      (cfg_wr_en_i),
    .cfg_wr_data_i    (cfg_wr_data_i),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .frames_checked_o (frames_checked)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: redraw tready on every falling edge
  initial begin
    forever begin
      @(negedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Hard stop, far beyond the slowest legal run
  initial begin
    #2ms;
    $display("semitone_pitched_sine_oscillator_core_test: errors");
    $finish;
  end

  // Offer one frame request; called and returns at a falling edge. Valid is
  // lowered only when a gap is taken, so back-to-back transactions keep it high.
  task automatic send_frame(input logic [6:0] pitch, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);   // noise on an idle bus
      s_axis_tlast  <= 1'($urandom);
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, pitch};
    s_axis_tlast  <= last;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Hold off the sender until every outstanding frame has come out
  task automatic drain_frames();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Write the base phase step; only call with the block idle
  task automatic write_base_step(input logic [31:0] value);
    cfg_wr_data_i <= value;
    cfg_wr_en_i   <= 1'b1;
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [6:0] random_pitch();
    // mostly in-range offsets, the rest anywhere in the 7-bit field
    if ($urandom_range(99) < 80) begin
      return 7'(int'($urandom_range(96)) - PitchLimit);
    end
    return 7'($urandom);
  endfunction

  int          directed_pitch [] = '{0, 1, -1, 11, 12, -12, -13, 23, 24, -24, 36,
                                     -36, 47, -47, 48, -48, 49, -49, 63, -64, 6};
  logic [31:0] phase_steps [PhaseCount];
  int          idle_table  [4] = '{0, 77, 0, 35};
  int          stall_table [4] = '{0, 0, 77, 35};

  initial begin
    phase_steps = '{BASE_INC_RESET, 32'hFFFF_FFFF, 32'd0, $urandom, 32'd1,
                    32'h8000_0000, 32'($urandom_range(32'h00FF_FFFF)), $urandom};

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: edges of the offset range, both clamp sides, octave boundaries
    foreach (directed_pitch[i]) begin
      send_frame(7'(directed_pitch[i]), 1'(i % 2));
    end
    // Zero step holds the phase, so the sample must repeat
    drain_frames();
    write_base_step(32'd0);
    send_frame(7'd5, 1'b0);
    send_frame(7'(-20), 1'b1);
    send_frame(7'd48, 1'b0);

    // Random: cycle the step register and the four pacing modes
    for (int p = 0; p < PhaseCount; p++) begin
      drain_frames();
      write_base_step(phase_steps[p]);
      src_idle_pct   = idle_table[p % 4];
      sink_stall_pct = stall_table[p % 4];
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (n == ItemsPerPhase / 2) begin
          drain_frames();
        end
        send_frame(random_pitch(), ($urandom_range(7) == 0));
      end
    end

    drain_frames();
    sink_stall_pct = 0;
    // Let the three-stage pipeline show any stray frame
    repeat (8) @(negedge clk_i);

    $display("checked %0d frames over %0d base step writes, offsets past both clamps,",
             frames_checked, settings_used);
    $display("with free-running, sender-gapped, receiver-stalled and mixed pacing");
    if (fail_count == 0 && pending == 0) begin
      $display("semitone_pitched_sine_oscillator_core_test: clean");
    end else begin
      $display("semitone_pitched_sine_oscillator_core_test: errors");
    end
    $finish;
  end

endmodule
